@@ src/cfq_pkg.sv @@
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 5;

    // Answer for a dequeue or peek on an empty queue
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

@@ src/cfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/circular_fifo_queue.sv @@
// Top level of the circular FIFO queue of signed 32-bit words.
//
// Each input item is one command: enqueue, dequeue or peek. One result item
// comes back per command with the word read (dequeue/peek), a status code and
// the full/empty flags after the step. Words live in a RAM of DEPTH entries
// with a registered read. An enqueue, an unknown command or a read on an empty
// queue is answered from the idle state, so such items can follow each other
// every clock while the result side keeps up. A dequeue or peek on a non-empty
// queue goes on to the read state to fetch the word from the RAM. The capacity
// register (1..DEPTH, clamped) is written only while the queue is empty; other
// writes are dropped. No clearing pass is needed after reset.
module circular_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic signed [cfq_pkg::WORD_W-1:0] value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [cfq_pkg::WORD_W-1:0] data,
    output logic [1:0]                      status,
    output logic                            now_full,
    output logic                            now_empty,
    // capacity register
    input  logic                            cfg_write,
    input  logic [cfq_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(DEPTH);

    // Next slot index, wrapping at the capacity in use
    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                               input logic [AW:0]   cap);
        logic [AW:0] n;
        n = {1'b0, i} + 1'b1;
        return (n >= cap) ? '0 : n[AW-1:0];
    endfunction

    function automatic logic is_full(input logic          empty,
                                     input logic [AW-1:0] head,
                                     input logic [AW-1:0] tail,
                                     input logic [AW:0]   cap);
        return !empty && (next_idx(tail, cap) == head);
    endfunction

    cfq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic            empty_reg, empty_next;
    logic [AW:0]     cap_reg, cap_next;

    logic                       out_valid_reg, out_valid_next;
    logic [cfq_pkg::WORD_W-1:0] data_reg, data_next;
    cfq_pkg::status_t           status_reg, status_next;
    logic                       full_reg, full_next;
    logic                       empty_out_reg, empty_out_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [cfq_pkg::WORD_W-1:0] ram_rdata;
    logic                       accept;
    logic [AW:0]                cap_cfg;

    // Slot storage
    cfq_ram #(
        .WIDTH (cfq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a command only when idle and the result register is free
    assign in_stall = (state_reg != cfq_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Clamp written capacity to 1..DEPTH
    always_comb
    begin
        if (32'(cfg_data) > 32'(DEPTH))
        begin
            cap_cfg = (AW + 1)'(DEPTH);
        end
        else if (cfg_data == '0)
        begin
            cap_cfg = (AW + 1)'(1);
        end
        else
        begin
            cap_cfg = (AW + 1)'(cfg_data);
        end
    end

    // Queue control: pointers, flags, RAM access, result fields
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        full_next      = full_reg;
        empty_out_next = empty_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_raddr      = head_reg;

        // result taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // capacity write, honored only while empty
        if (cfg_write && empty_reg)
        begin
            cap_next  = cap_cfg;
            head_next = '0;
            tail_next = '0;
        end

        unique case (state_reg)
            cfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    data_next      = '0;
                    status_next    = cfq_pkg::ST_DONE;
                    out_valid_next = 1'b1;
                    case (cfq_pkg::cmd_t'(command))
                        cfq_pkg::CMD_ENQ:
                        begin
                            if (is_full(empty_reg, head_reg, tail_reg, cap_reg))
                            begin
                                status_next = cfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                if (empty_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b0;
                                end
                                else
                                begin
                                    tail_next = next_idx(tail_reg, cap_reg);
                                end
                                ram_we    = 1'b1;
                                ram_waddr = tail_next;
                            end
                        end
                        cfq_pkg::CMD_DEQ,
                        cfq_pkg::CMD_PEEK:
                        begin
                            if (empty_reg)
                            begin
                                data_next   = cfq_pkg::WORD_MIN;
                                status_next = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // word comes from RAM next cycle
                                out_valid_next = 1'b0;
                                state_next     = cfq_pkg::S_READ;
                                if (cfq_pkg::cmd_t'(command) == cfq_pkg::CMD_DEQ)
                                begin
                                    if (head_reg == tail_reg)
                                    begin
                                        empty_next = 1'b1;
                                        head_next  = '0;
                                        tail_next  = '0;
                                    end
                                    else
                                    begin
                                        head_next = next_idx(head_reg, cap_reg);
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            // unknown command: no operation
                        end
                    endcase
                    full_next      = is_full(empty_next, head_next, tail_next, cap_next);
                    empty_out_next = empty_next;
                end
            end
            cfq_pkg::S_READ:
            begin
                data_next      = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = cfq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cfq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            cap_reg       <= (AW + 1)'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        status_reg    <= status_next;
        full_reg      <= full_next;
        empty_out_reg <= empty_out_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign now_full  = full_reg;
    assign now_empty = empty_out_reg;

endmodule

@@ tb/cfq_checker.sv @@
// Checker for the circular FIFO queue: predicts every result item and compares it.
`timescale 1ns / 100ps

module cfq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic signed [cfq_pkg::WORD_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [cfq_pkg::WORD_W-1:0] data,
    input  logic [1:0]                        status,
    input  logic                              now_full,
    input  logic                              now_empty,
    input  logic                              cfg_write,
    input  logic [cfq_pkg::CFG_W-1:0]         cfg_data,
    output int                                errors,
    output int                                pending,
    output logic                              model_empty
);

    typedef struct packed {
        logic [cfq_pkg::WORD_W-1:0] data;
        cfq_pkg::status_t           status;
        logic                       full;
        logic                       empty;
    } result_t;

    // Expected result items, oldest first
    result_t expected_q[$];

    // Predicted queue contents
    logic [cfq_pkg::WORD_W-1:0] word_mem [DEPTH];
    int                         head_pos;
    int                         tail_pos;
    bit                         mem_empty;
    int                         slots_in_use;

    function automatic int step_pos(int i);
        int n;
        n = i + 1;
        return (n >= slots_in_use) ? 0 : n;
    endfunction

    function automatic bit at_capacity();
        return !mem_empty && (step_pos(tail_pos) == head_pos);
    endfunction

    // Capacity write: clamped to 1..DEPTH, dropped unless empty
    task automatic load_capacity(input logic [cfq_pkg::CFG_W-1:0] raw);
        int c;
        c = int'(raw);
        if (!mem_empty)
            return;
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        slots_in_use = c;
        head_pos = 0;
        tail_pos = 0;
    endtask

    // Apply one accepted command and queue the result it should give
    task automatic predict_command(input logic [1:0] cmd,
                                   input logic [cfq_pkg::WORD_W-1:0] word);
        result_t r;
        r.data   = '0;
        r.status = cfq_pkg::ST_DONE;
        case (cmd)
            cfq_pkg::CMD_ENQ:
            begin
                if (at_capacity())
                    r.status = cfq_pkg::ST_FULL;
                else
                begin
                    if (mem_empty)
                    begin
                        head_pos  = 0;
                        tail_pos  = 0;
                        mem_empty = 1'b0;
                    end
                    else
                        tail_pos = step_pos(tail_pos);
                    word_mem[tail_pos] = word;
                end
            end
            cfq_pkg::CMD_DEQ, cfq_pkg::CMD_PEEK:
            begin
                if (mem_empty)
                begin
                    r.data   = cfq_pkg::WORD_MIN;
                    r.status = cfq_pkg::ST_EMPTY;
                end
                else
                begin
                    r.data = word_mem[head_pos];
                    if (cmd == cfq_pkg::CMD_DEQ)
                    begin
                        if (head_pos == tail_pos)
                        begin
                            mem_empty = 1'b1;
                            head_pos  = 0;
                            tail_pos  = 0;
                        end
                        else
                            head_pos = step_pos(head_pos);
                    end
                end
            end
            default: ;
        endcase
        r.full  = at_capacity();
        r.empty = mem_empty;
        expected_q.push_back(r);
    endtask

    // Compare one accepted result item with the oldest expectation
    task automatic check_result();
        result_t e;
        if (expected_q.size() == 0)
        begin
            $error("result item with no command waiting: data %0d status %0d", data, status);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (data !== e.data)
        begin
            $error("data mismatch: expected %0d, actual %0d", $signed(e.data), data);
            errors++;
        end
        if (status !== e.status)
        begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            errors++;
        end
        if (now_full !== e.full)
        begin
            $error("now_full mismatch: expected %0d, actual %0d", e.full, now_full);
            errors++;
        end
        if (now_empty !== e.empty)
        begin
            $error("now_empty mismatch: expected %0d, actual %0d", e.empty, now_empty);
            errors++;
        end
    endtask

    // Watch the channels and the capacity port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            head_pos     = 0;
            tail_pos     = 0;
            mem_empty    = 1'b1;
            slots_in_use = DEPTH;
            errors       = 0;
            pending     <= 0;
            model_empty <= 1'b1;
        end
        else
        begin
            if (cfg_write)
                load_capacity(cfg_data);
            if (in_valid && !in_stall)
                predict_command(command, value);
            if (out_valid && !out_stall)
                check_result();
            pending     <= expected_q.size();
            model_empty <= mem_empty;
        end
    end

endmodule

@@ tb/testbench.sv @@
// Testbench top for the circular FIFO queue: drives commands and capacity, gives the verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 150;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    cfq_pkg::cmd_t              command   = cfq_pkg::CMD_NOP;
    logic [cfq_pkg::WORD_W-1:0] value     = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [cfq_pkg::WORD_W-1:0] data;
    logic [1:0]                 status;
    logic                       now_full;
    logic                       now_empty;
    logic                       cfg_write = 1'b0;
    logic [cfq_pkg::CFG_W-1:0]  cfg_data  = '0;

    int                errors;
    int                pending;
    logic              model_empty;

    bit                calm       = 1'b0;
    int                stall_left = 0;
    int                stall_pick;
    int                cycles;

    circular_fifo_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .now_full  (now_full),
        .now_empty (now_empty),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    cfq_checker #(
        .DEPTH(DEPTH)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .status      (status),
        .now_full    (now_full),
        .now_empty   (now_empty),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .model_empty (model_empty)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure: mostly short bursts, now and then a long stall
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 65)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 50);
            end
        end
    end

    // Idle cycles before the next command item
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic cfq_pkg::cmd_t pick_command(int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return cfq_pkg::CMD_NOP;
        if ($urandom_range(0, 99) < enq_pct)
            return cfq_pkg::CMD_ENQ;
        return ($urandom_range(0, 9) < 7) ? cfq_pkg::CMD_DEQ : cfq_pkg::CMD_PEEK;
    endfunction

    function automatic logic [cfq_pkg::WORD_W-1:0] pick_word();
        logic [cfq_pkg::WORD_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       w = cfq_pkg::WORD_MIN;
                1:       w = 32'h7FFF_FFFF;
                2:       w = '0;
                default: w = '1;
            endcase
        end
        return w;
    endfunction

    // Present one item and hold it until accepted; valid stays high on return
    task automatic push_cmd(input cfq_pkg::cmd_t c, input logic [cfq_pkg::WORD_W-1:0] w);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        value    <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending, wait for every result, then let the pipeline settle
    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Dequeue until the queue is empty so capacity may be written
    task automatic empty_queue();
        wait_drained();
        while (!model_empty)
        begin
            push_cmd(cfq_pkg::CMD_DEQ, $urandom);
            wait_drained();
        end
    endtask

    task automatic write_capacity(input logic [cfq_pkg::CFG_W-1:0] c);
        empty_queue();
        cfg_write <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int ph;
        int n;
        int enq_pct;
        logic [cfq_pkg::CFG_W-1:0] cap;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset capacity: reads on empty, unknown command, extreme words
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_PEEK, $urandom);
        push_cmd(cfq_pkg::CMD_NOP, $urandom);
        push_cmd(cfq_pkg::CMD_ENQ, 32'h7FFF_FFFF);
        push_cmd(cfq_pkg::CMD_ENQ, cfq_pkg::WORD_MIN);
        push_cmd(cfq_pkg::CMD_PEEK, $urandom);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_NOP, '1);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_ENQ, '0);

        // Zero capacity clamps to one slot: full after a single word
        write_capacity('0);
        push_cmd(cfq_pkg::CMD_ENQ, '1);
        push_cmd(cfq_pkg::CMD_ENQ, 32'h1234_5678);
        push_cmd(cfq_pkg::CMD_PEEK, $urandom);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);

        // Two slots: full refusal and index wrap
        write_capacity(5'd2);
        push_cmd(cfq_pkg::CMD_ENQ, 32'h0000_0001);
        push_cmd(cfq_pkg::CMD_ENQ, 32'hFFFF_FFFE);
        push_cmd(cfq_pkg::CMD_ENQ, 32'h5555_AAAA);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_ENQ, 32'hAAAA_5555);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);
        push_cmd(cfq_pkg::CMD_DEQ, $urandom);

        // Random phases, each with its own capacity and traffic mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 6)
                0:       cap = 5'd1;
                1:       cap = 5'(DEPTH);
                2:       cap = 5'($urandom_range(DEPTH + 1, 31));
                3:       cap = '0;
                4:       cap = 5'd2;
                default: cap = 5'($urandom_range(3, DEPTH - 1));
            endcase
            if (ph == PHASES - 1)
                cap = '1;
            write_capacity(cap);
            calm <= (ph % 4 == 3);
            enq_pct = 50;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Swing between filling and draining
                if (n % 20 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       enq_pct = 15;
                        1:       enq_pct = 50;
                        default: enq_pct = 85;
                    endcase
                end
                push_cmd(pick_command(enq_pct), pick_word());
            end
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
